// ===== rtl/rate_monotonic_task_scheduler_macros.svh =====
// Assertion macros for the rate-monotonic task scheduler.
// Needs a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef RATE_MONOTONIC_TASK_SCHEDULER_MACROS_SVH
`define RATE_MONOTONIC_TASK_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMTS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rmts_pkg.sv =====
// Shared types and constants of the rate-monotonic task scheduler.
// No dependencies.
package rmts_pkg;

	localparam int ID_W     = 22;
	localparam int PERIOD_W = 16;
	localparam int COST_W   = 16;
	localparam int SHARE_W  = 11;
	localparam int TIME_W   = 32;
	localparam int LIMIT_W  = 10;
	localparam int DVD_W    = 26;
	localparam int DIV_STEPS = DVD_W;
	localparam int DIV_CNT_W = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd693;
	localparam logic [9:0] PER_MILLE = 10'd1000;
	localparam logic [SHARE_W-1:0] SHARE_MAX = 11'd2047;

	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_YIELD    = 2'd1,
		OP_DEREG    = 2'd2,
		OP_TICK     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_REJECTED = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_SCAN,
		S_WRITE
	} state_t;

	typedef struct packed {
		logic [1:0]          op;
		logic [ID_W-1:0]     task_id;
		logic [PERIOD_W-1:0] task_period;
		logic [COST_W-1:0]   task_cost;
	} in_word_t;

	typedef struct packed {
		logic [1:0]      status;
		logic            running_valid;
		logic [ID_W-1:0] running_id;
	} out_word_t;

	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [PERIOD_W-1:0] period;
		logic [SHARE_W-1:0]  share;
		logic [TIME_W-1:0]   release_ms;
	} entry_t;

	// True when time t is at or before now, modulo 2^32.
	function automatic logic reached(input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] d;
		d = now - t;
		return !d[TIME_W-1];
	endfunction

endpackage

// ===== rtl/rate_monotonic_task_scheduler.sv =====
// Top level of the rate-monotonic task scheduler: task table memory, scan sequencer,
// share divider and result register. Depends on rmts_pkg and the assertion macro header.

// Each word on cmd is one operation: register, yield, deregister or a one-millisecond
// tick. A word is taken at a rising edge where start is high and busy is low, and
// exactly one result word follows on result, marked by done for a single cycle; the
// receiver cannot stall it, so it must take the word in that cycle. Every operation
// reads the whole task table once through its registered read port, so a yield,
// deregister or tick keeps busy high through the scan and the write-back, and its
// result appears in the first cycle that busy is low again. A register first runs the
// bit-serial share divider, one quotient bit per cycle, when the period is nonzero. A
// new word may be started in the same cycle that done is shown. The utilization limit
// may be written on cfg_we/cfg_data only while busy is low and no result is pending;
// it resets to 693 per mille.
`include "rate_monotonic_task_scheduler_macros.svh"

module rate_monotonic_task_scheduler
	import rmts_pkg::*;
#(
	parameter int MAX_TASKS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  in_word_t           cmd,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_data,
	output logic               done,
	output out_word_t          result
);

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int SW = SHARE_W + IW + 1;
	localparam logic [IW-1:0] LAST = IW'(MAX_TASKS - 1);

	// Control state.
	state_t state_q, state_d;
	logic               div_en, scan_en, wr_en;
	logic [LIMIT_W-1:0] limit_q;
	logic [TIME_W-1:0]  now_q;
	logic [MAX_TASKS-1:0] valid_q, run_q;
	logic               cur_valid_q;
	logic [IW-1:0]      cur_idx_q;
	logic [ID_W-1:0]    cur_id_q;

	// The accepted operation.
	op_t                 op_q;
	logic [ID_W-1:0]     id_q;
	logic [PERIOD_W-1:0] period_q;

	// Share divider.
	logic [DVD_W-1:0]     dvd_q, quo_q;
	logic [PERIOD_W-1:0]  rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [PERIOD_W:0]    trial;
	logic                 qbit;
	logic [SHARE_W-1:0]   share_sat;

	// Task table memory and its read stage.
	entry_t        mem_q [MAX_TASKS];
	logic [IW-1:0] rd_addr_q;
	logic          issue_done_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	entry_t        ent_s1;

	// Scan accumulators.
	logic [SW-1:0]       sum_q;
	logic                match_found_q, best_found_q, free_found_q, released_q;
	logic [IW-1:0]       match_idx_q, best_idx_q, free_idx_q;
	entry_t              match_ent_q;
	logic [PERIOD_W-1:0] best_period_q;
	logic [ID_W-1:0]     best_id_q;

	logic accept;
	assign accept = start && !busy;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op_t'(cmd.op) == OP_REGISTER && cmd.task_period != '0) state_d = S_DIV;
					else state_d = S_SCAN;
				end
			end
			S_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (vld_s1 && idx_s1 == LAST) state_d = S_WRITE;
			end
			S_WRITE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		busy    = 1'b1;
		div_en  = 1'b0;
		scan_en = 1'b0;
		wr_en   = 1'b0;
		unique case (state_q)
			S_IDLE:  busy    = 1'b0;
			S_DIV:   div_en  = 1'b1;
			S_SCAN:  scan_en = 1'b1;
			S_WRITE: wr_en   = 1'b1;
			default: busy    = 1'b1;
		endcase
	end

	// Restoring division of cost * 1000 by the period.
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign qbit  = trial >= {1'b0, period_q};
	assign share_sat = (quo_q > DVD_W'(SHARE_MAX)) ? SHARE_MAX : quo_q[SHARE_W-1:0];

	// Per-entry decisions for the entry in the read stage.
	logic e_v, e_r, lookup, hit, due, cand, better, free;
	logic [TIME_W-1:0] next_rel, new_rel;
	always_comb begin
		e_v    = valid_q[idx_s1];
		e_r    = run_q[idx_s1];
		lookup = (op_q == OP_YIELD) || (op_q == OP_DEREG);
		hit    = vld_s1 && lookup && e_v && ent_s1.id == id_q && !match_found_q;
		due    = vld_s1 && op_q == OP_TICK && e_v && !e_r && reached(ent_s1.release_ms, now_q);
		// A matched entry drops out of the dispatch: yield parks it, deregister frees it.
		cand   = vld_s1 && e_v && (e_r || due) && !hit;
		better = cand && (!best_found_q || ent_s1.period < best_period_q);
		free   = vld_s1 && !e_v && !free_found_q;
		next_rel = ent_s1.release_ms + TIME_W'(ent_s1.period);
		new_rel  = reached(next_rel, now_q) ? now_q + TIME_W'(ent_s1.period) : next_rel;
	end

	// Final decision at write-back.
	logic [SW-1:0] reg_total;
	logic          reg_ok, reg_go, do_dispatch, mem_we;
	logic [IW-1:0] mem_wa;
	entry_t        mem_wd;
	status_t       status_d;
	always_comb begin
		reg_total   = sum_q + SW'(share_sat);
		reg_ok      = period_q != '0 && reg_total <= SW'(limit_q);
		reg_go      = 1'b0;
		do_dispatch = 1'b0;
		mem_we      = 1'b0;
		mem_wa      = match_idx_q;
		mem_wd      = match_ent_q;
		status_d    = ST_OK;
		case (op_q)
			OP_REGISTER: begin
				mem_wa = free_idx_q;
				mem_wd.id         = id_q;
				mem_wd.period     = period_q;
				mem_wd.share      = share_sat;
				mem_wd.release_ms = now_q;
				if (!reg_ok) status_d = ST_REJECTED;
				else if (!free_found_q) status_d = ST_FULL;
				else reg_go = 1'b1;
				mem_we = reg_go;
			end
			OP_YIELD: begin
				if (!match_found_q) status_d = ST_NOTFOUND;
				else begin
					mem_we = 1'b1;
					do_dispatch = cur_valid_q && cur_idx_q == match_idx_q;
				end
			end
			OP_DEREG: begin
				if (!match_found_q) status_d = ST_NOTFOUND;
				else do_dispatch = 1'b1;
			end
			default: do_dispatch = released_q;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			limit_q     <= LIMIT_RESET;
			now_q       <= '0;
			valid_q     <= '0;
			run_q       <= '0;
			cur_valid_q <= 1'b0;
			cur_idx_q   <= '0;
			cur_id_q    <= '0;
			done        <= 1'b0;
			result      <= '0;
			vld_s1      <= 1'b0;
			issue_done_q <= 1'b0;
			rd_addr_q   <= '0;
			div_cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			done    <= wr_en;
			if (cfg_we) limit_q <= cfg_data;
			if (accept) begin
				rd_addr_q    <= '0;
				issue_done_q <= 1'b0;
				div_cnt_q    <= '0;
				if (op_t'(cmd.op) == OP_TICK) now_q <= now_q + 1'b1;
			end
			if (div_en) div_cnt_q <= div_cnt_q + 1'b1;
			vld_s1 <= scan_en && !issue_done_q;
			if (scan_en && !issue_done_q) begin
				if (rd_addr_q == LAST) issue_done_q <= 1'b1;
				else rd_addr_q <= rd_addr_q + 1'b1;
			end
			if (scan_en && due) run_q[idx_s1] <= 1'b1;
			if (wr_en) begin
				if (reg_go) begin
					valid_q[free_idx_q] <= 1'b1;
					run_q[free_idx_q]   <= 1'b1;
				end
				if (op_q == OP_YIELD && match_found_q) run_q[match_idx_q] <= 1'b0;
				if (op_q == OP_DEREG && match_found_q) begin
					valid_q[match_idx_q] <= 1'b0;
					run_q[match_idx_q]   <= 1'b0;
				end
				result.status <= status_d;
				if (do_dispatch) begin
					cur_valid_q <= best_found_q;
					cur_idx_q   <= best_found_q ? best_idx_q : '0;
					cur_id_q    <= best_found_q ? best_id_q : '0;
					result.running_valid <= best_found_q;
					result.running_id    <= best_found_q ? best_id_q : '0;
				end else begin
					result.running_valid <= cur_valid_q;
					result.running_id    <= cur_id_q;
				end
			end
		end
	end

	// Operation, divider and scan accumulators.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q          <= op_t'(cmd.op);
			id_q          <= cmd.task_id;
			period_q      <= cmd.task_period;
			dvd_q         <= DVD_W'(cmd.task_cost) * DVD_W'(PER_MILLE);
			rem_q         <= '0;
			quo_q         <= '0;
			sum_q         <= '0;
			match_found_q <= 1'b0;
			best_found_q  <= 1'b0;
			free_found_q  <= 1'b0;
			released_q    <= 1'b0;
		end
		if (div_en) begin
			rem_q <= qbit ? PERIOD_W'(trial - {1'b0, period_q}) : trial[PERIOD_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], qbit};
		end
		if (scan_en && vld_s1) begin
			if (e_v) sum_q <= sum_q + SW'(ent_s1.share);
			if (due) released_q <= 1'b1;
			if (free) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
			if (hit) begin
				match_found_q <= 1'b1;
				match_idx_q   <= idx_s1;
				match_ent_q   <= '{ent_s1.id, ent_s1.period, ent_s1.share, new_rel};
			end
			if (better) begin
				best_found_q  <= 1'b1;
				best_idx_q    <= idx_s1;
				best_period_q <= ent_s1.period;
				best_id_q     <= ent_s1.id;
			end
		end
	end

	// Task table: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en && mem_we) mem_q[mem_wa] <= mem_wd;
		if (scan_en && !issue_done_q) begin
			ent_s1 <= mem_q[rd_addr_q];
			idx_s1 <= rd_addr_q;
		end
	end

	`RMTS_ASSERT_NEXT(a_start_busy, accept, busy, "accepted word did not raise busy")
	`RMTS_ASSERT_NEXT(a_write_done, wr_en, done && !busy, "write-back gave no result")
	`RMTS_ASSERT_SAME(a_idle_id, done && !result.running_valid, result.running_id == '0,
		"running id not zero with no task selected")
	`RMTS_ASSERT_SAME(a_cur_valid, cur_valid_q, valid_q[cur_idx_q], "running task not in table")

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the rate-monotonic task scheduler.
// Needs rmts_pkg and the rate_monotonic_task_scheduler top level; reads no files.
`timescale 1ns / 100ps

module tb;
	import rmts_pkg::*;

	localparam int N_TASKS = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_word_t cmd = '0;
	logic cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_data = '0;
	logic done;
	out_word_t result;

	rate_monotonic_task_scheduler #(.MAX_TASKS(N_TASKS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.done(done),
		.result(result)
	);

	always #10 clk = ~clk;

	// Shadow copy of the task table, the running selection, the millisecond
	// counter and the admission limit, kept in step with every accepted word.
	logic               tbl_valid   [N_TASKS];
	logic [ID_W-1:0]    tbl_id      [N_TASKS];
	logic [15:0]        tbl_period  [N_TASKS];
	logic [SHARE_W-1:0] tbl_share   [N_TASKS];
	logic               tbl_runnable[N_TASKS];
	logic [31:0]        tbl_release [N_TASKS];
	logic               run_valid;
	int                 run_index;
	logic [31:0]        clock_ms;
	logic [LIMIT_W-1:0] util_limit;

	out_word_t pending_results[$];
	int mismatches = 0;
	logic [ID_W-1:0] pid_pool[8];

	// True when time t is at or before now, with the 32-bit counter wrapping.
	function automatic logic is_due(input logic [31:0] t, input logic [31:0] now);
		logic [31:0] d;
		d = now - t;
		return !d[31];
	endfunction

	function automatic int lookup_pid(input logic [ID_W-1:0] id);
		for (int i = 0; i < N_TASKS; i++)
			if (tbl_valid[i] && tbl_id[i] == id)
				return i;
		return -1;
	endfunction

	// Shortest period among runnable tasks wins; a strict compare keeps the
	// lowest index on a tie.
	task automatic pick_running();
		run_valid = 1'b0;
		run_index = 0;
		for (int i = 0; i < N_TASKS; i++)
			if (tbl_valid[i] && tbl_runnable[i])
				if (!run_valid || tbl_period[i] < tbl_period[run_index]) begin
					run_index = i;
					run_valid = 1'b1;
				end
	endtask

	task automatic predict_schedule(input in_word_t w, output out_word_t r);
		int idx;
		int slot;
		logic [31:0] share;
		logic [31:0] total;
		logic [31:0] next;
		logic released;
		status_t st;
		st = ST_OK;
		case (op_t'(w.op))
			OP_REGISTER: begin
				if (w.task_period == 0) begin
					st = ST_REJECTED;
				end else begin
					share = (32'(w.task_cost) * 32'd1000) / 32'(w.task_period);
					if (share > 32'd2047)
						share = 32'd2047;
					total = share;
					for (int i = 0; i < N_TASKS; i++)
						if (tbl_valid[i])
							total += 32'(tbl_share[i]);
					slot = -1;
					for (int i = N_TASKS - 1; i >= 0; i--)
						if (!tbl_valid[i])
							slot = i;
					if (total > 32'(util_limit)) begin
						st = ST_REJECTED;
					end else if (slot < 0) begin
						st = ST_FULL;
					end else begin
						tbl_valid[slot] = 1'b1;
						tbl_id[slot] = w.task_id;
						tbl_period[slot] = w.task_period;
						tbl_share[slot] = share[SHARE_W-1:0];
						tbl_runnable[slot] = 1'b1;
						tbl_release[slot] = clock_ms;
					end
				end
			end
			OP_YIELD: begin
				idx = lookup_pid(w.task_id);
				if (idx < 0) begin
					st = ST_NOTFOUND;
				end else begin
					next = tbl_release[idx] + 32'(tbl_period[idx]);
					tbl_release[idx] = is_due(next, clock_ms) ?
						clock_ms + 32'(tbl_period[idx]) : next;
					tbl_runnable[idx] = 1'b0;
					if (run_valid && run_index == idx)
						pick_running();
				end
			end
			OP_DEREG: begin
				idx = lookup_pid(w.task_id);
				if (idx < 0) begin
					st = ST_NOTFOUND;
				end else begin
					tbl_valid[idx] = 1'b0;
					tbl_runnable[idx] = 1'b0;
					pick_running();
				end
			end
			default: begin
				clock_ms += 1;
				released = 1'b0;
				for (int i = 0; i < N_TASKS; i++)
					if (tbl_valid[i] && !tbl_runnable[i] && is_due(tbl_release[i], clock_ms)) begin
						tbl_runnable[i] = 1'b1;
						released = 1'b1;
					end
				if (released)
					pick_running();
			end
		endcase
		r.status = st;
		r.running_valid = run_valid;
		r.running_id = run_valid ? tbl_id[run_index] : '0;
	endtask

	task automatic report_mismatch(input string field, input int want, input int got);
		$display("%0t: result %s mismatch, expected %0d, got %0d", $time, field, want, got);
		mismatches++;
	endtask

	// Every done pulse must match the oldest expected word; the receiver
	// cannot stall, so the word is taken in the cycle it is shown.
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", 0, 1);
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", want.status, result.status);
				if (result.running_valid !== want.running_valid)
					report_mismatch("running_valid", want.running_valid, result.running_valid);
				if (result.running_id !== want.running_id)
					report_mismatch("running_id", want.running_id, result.running_id);
			end
		end
	end

	// Sends one command word after an idle gap. With no gap start stays high
	// from the previous word, so it is never dropped and raised in one step.
	task automatic send_word(input op_t op, input logic [ID_W-1:0] id,
			input logic [15:0] per, input logic [15:0] cost, input int gap);
		in_word_t w;
		out_word_t r;
		w.op = op;
		w.task_id = id;
		w.task_period = per;
		w.task_cost = cost;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (busy);
		predict_schedule(w, r);
		pending_results.push_back(r);
	endtask

	// Mostly short gaps with the occasional long one.
	function automatic int random_gap();
		if ($urandom_range(0, 9) < 6)
			return 0;
		else if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Waits for every expected word to arrive and the block to settle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() > 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		util_limit = v;
	endtask

	// Extremes of the fields, every operation and the named special cases:
	// zero period, unknown pid, duplicate pid, removing the running task.
	task automatic test_directed();
		send_word(OP_TICK, '0, 16'd1, '0, 0);
		send_word(OP_YIELD, 22'd5, 16'd1, '0, 1);
		send_word(OP_DEREG, 22'h3FFFFF, 16'd1, '0, 0);
		send_word(OP_REGISTER, '0, 16'd0, 16'd1, 0);
		send_word(OP_REGISTER, 22'h3FFFFF, 16'hFFFF, 16'hFFFF, 0);
		send_word(OP_REGISTER, '0, 16'd10, 16'd1, 2);
		send_word(OP_REGISTER, '0, 16'd4, 16'd1, 0);
		send_word(OP_REGISTER, 22'h3FFFFF, 16'd5, 16'd1, 0);
		send_word(OP_YIELD, '0, 16'd1, '0, 0);
		send_word(OP_YIELD, '0, 16'd1, '0, 0);
		repeat (5) send_word(OP_TICK, '0, 16'd1, '0, 0);
		send_word(OP_YIELD, 22'h3FFFFF, 16'd1, '0, 0);
		send_word(OP_TICK, '0, 16'd1, '0, 3);
		send_word(OP_DEREG, '0, 16'd1, '0, 0);
		send_word(OP_DEREG, '0, 16'd1, '0, 0);
		send_word(OP_REGISTER, 22'd9, 16'd1, 16'd0, 0);
		send_word(OP_DEREG, 22'h3FFFFF, 16'd1, '0, 0);
		send_word(OP_DEREG, 22'd9, 16'd1, '0, 0);
	endtask

	// Wide-open limit and zero-cost tasks fill every slot, then one more
	// register must report a full table.
	task automatic test_table_full();
		write_limit(10'd1023);
		for (int i = 0; i <= N_TASKS; i++)
			send_word(OP_REGISTER, 22'(100 + i), 16'(N_TASKS + 1 - i), 16'd0, random_gap());
		send_word(OP_TICK, '0, 16'd1, '0, 0);
		for (int i = 0; i < N_TASKS; i++)
			send_word(OP_DEREG, 22'(100 + i), 16'd1, '0, random_gap());
	endtask

	// At a zero limit only zero-share tasks may be admitted.
	task automatic test_limit_extremes();
		write_limit(10'd0);
		send_word(OP_REGISTER, 22'd1, 16'd1000, 16'd1, 0);
		send_word(OP_REGISTER, 22'd1, 16'd1001, 16'd1, 0);
		send_word(OP_DEREG, 22'd1, 16'd1, '0, 0);
		write_limit(10'd1000);
		send_word(OP_REGISTER, 22'd2, 16'd2, 16'd1, 0);
		send_word(OP_REGISTER, 22'd3, 16'd2, 16'd1, 0);
		send_word(OP_REGISTER, 22'd4, 16'd1000, 16'd1, 0);
		send_word(OP_DEREG, 22'd2, 16'd1, '0, 0);
		send_word(OP_DEREG, 22'd3, 16'd1, '0, 0);
	endtask

	// One random word: mostly operations on a small pid pool with short
	// periods so tasks get released and dispatched; some fully random noise.
	task automatic random_word(input int gap);
		int sel;
		logic [ID_W-1:0] id;
		logic [15:0] per;
		logic [15:0] cost;
		sel = $urandom_range(0, 99);
		id = ($urandom_range(0, 9) == 0) ? 22'($urandom) : pid_pool[$urandom_range(0, 7)];
		per = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
		cost = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
		if (sel < 40)
			send_word(OP_TICK, 22'($urandom), per, cost, gap);
		else if (sel < 62)
			send_word(OP_REGISTER, id, per, cost, gap);
		else if (sel < 87)
			send_word(OP_YIELD, id, per, cost, gap);
		else
			send_word(OP_DEREG, id, per, cost, gap);
	endtask

	// Random phases under several limits, including one back-to-back stretch
	// and one pause where the sender waits for every result to come back.
	task automatic test_random();
		logic [LIMIT_W-1:0] limits[5];
		limits = '{10'd693, 10'd1000, 10'd1023, 10'($urandom), 10'd300};
		foreach (limits[k]) begin
			write_limit(limits[k]);
			for (int n = 0; n < 100; n++)
				random_word(k == 1 ? 0 : random_gap());
		end
		for (int n = 0; n < 20; n++)
			random_word(random_gap());
		drain();
		for (int n = 0; n < 20; n++)
			random_word(random_gap());
		write_limit(10'd693);
	endtask

	initial begin
		pid_pool = '{22'd0, 22'h3FFFFF, 22'h155555, 22'h2AAAAA,
			22'($urandom), 22'($urandom), 22'd7, 22'd8};
		for (int i = 0; i < N_TASKS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_runnable[i] = 1'b0;
			tbl_id[i] = '0;
			tbl_period[i] = '0;
			tbl_share[i] = '0;
			tbl_release[i] = '0;
		end
		run_valid = 1'b0;
		run_index = 0;
		clock_ms = '0;
		util_limit = LIMIT_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_limit_extremes();
		test_random();
		drain();
		repeat (60) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Generous bound on the length of the whole run.
	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

endmodule
